// ===== sv/i2cm_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
package i2cm_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_TIMEOUT = 1'd1;

    localparam logic [CFG_W-1:0] HALF_PERIOD_RST     = 16'd5;
    localparam logic [CFG_W-1:0] STRETCH_TIMEOUT_RST = 16'd50000;

    // Raw command codes on the bus
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Classified command kinds handed to the sequencer
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       scl_in;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [1:0] status;
        logic       done_res;
        logic       ready_res;
        logic       sda_drive_low;
        logic       scl_drive_low;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== sv/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: input stage, queue and bus sequencer.
// A tick passes the input register, the queue and the output register before m_tdata.
// One tick per cycle unless m_tready stalls; the sequencer advances the bus once per tick.
// Input and sequencer are split by a four-entry queue, so either side may stall alone.
// Reset (rst_n low, asynchronous): engine idle, both lines released, timing registers
// back to half period 5 and stretch timeout 50000, queue and output register empty.
module i2c_master_bit_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]     s_tdata,  // tx_byte[7:0], send_nack, scl_in, sda_in
    input  logic [i2cm_pkg::IN_USER_W-1:0]     s_tuser,  // command[2:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2cm_pkg::OUT_DATA_W-1:0]    m_tdata,  // scl_drive_low, sda_drive_low,
                                                         // ready_res, done_res, status[1:0],
                                                         // rx_byte[7:0]
    input  logic                               cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cm_pkg::CFG_W-1:0]         cfg_data
);

    logic              push;
    logic              pop;
    i2cm_pkg::tick_t   push_item;
    i2cm_pkg::tick_t   head;
    i2cm_pkg::q_stat_t q_stat;
    i2cm_pkg::result_t result;

    i2cm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    i2cm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    i2cm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {2'b00, result};

endmodule

// ===== sv/i2cm_front.sv =====
// Input stage: takes ticks, classifies the command and pushes them to the queue.
module i2cm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]    s_tdata,  // tx_byte, send_nack, scl_in, sda_in
    input  logic [i2cm_pkg::IN_USER_W-1:0]    s_tuser,  // command
    input  i2cm_pkg::q_stat_t                 q_stat,
    output logic                              push,
    output i2cm_pkg::tick_t                   push_item
);

    logic            fr_valid_reg;
    logic            fr_valid_next;
    i2cm_pkg::tick_t fr_item_reg;
    i2cm_pkg::tick_t fr_item_next;
    logic            load;

    assign s_tready = !fr_valid_reg || !q_stat.full;
    assign load     = s_tvalid && s_tready;
    assign push     = fr_valid_reg && !q_stat.full;
    assign push_item = fr_item_reg;

    always_comb
    begin
        fr_item_next.tx_byte   = s_tdata[7:0];
        fr_item_next.send_nack = s_tdata[8];
        fr_item_next.scl_in    = s_tdata[9];
        fr_item_next.sda_in    = s_tdata[10];
        // map unknown command codes to KIND_NONE here so the sequencer treats them as no command
        unique case (s_tuser)
            i2cm_pkg::CMD_START: fr_item_next.kind = i2cm_pkg::KIND_START;
            i2cm_pkg::CMD_STOP:  fr_item_next.kind = i2cm_pkg::KIND_STOP;
            i2cm_pkg::CMD_WRITE: fr_item_next.kind = i2cm_pkg::KIND_WRITE;
            i2cm_pkg::CMD_READ:  fr_item_next.kind = i2cm_pkg::KIND_READ;
            default:             fr_item_next.kind = i2cm_pkg::KIND_NONE;
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
        else
        begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fr_item_reg <= fr_item_next;
        end
    end

endmodule

// ===== sv/i2cm_queue.sv =====
// Short queue of classified ticks between the input stage and the sequencer.
module i2cm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  i2cm_pkg::tick_t   push_item,
    input  logic              pop,
    output i2cm_pkg::tick_t   head,
    output i2cm_pkg::q_stat_t q_stat
);

    i2cm_pkg::tick_t                  mem [i2cm_pkg::Q_DEPTH];
    logic [i2cm_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [i2cm_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [i2cm_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [i2cm_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [i2cm_pkg::Q_CNT_W-1:0]     count_reg;
    logic [i2cm_pkg::Q_CNT_W-1:0]     count_next;

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == i2cm_pkg::Q_CNT_W'(i2cm_pkg::Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    as_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("queue written while full");
    as_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("queue read while empty");
    as_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= i2cm_pkg::Q_CNT_W'(i2cm_pkg::Q_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== sv/i2cm_seq.sv =====
// Bus sequencer: runs one tick of the start/stop/write/read sequences per queued item.
module i2cm_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_W-1:0]      cfg_data,
    input  i2cm_pkg::tick_t                 head,
    input  i2cm_pkg::q_stat_t               q_stat,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output i2cm_pkg::result_t               m_result
);

    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_ST_D1  = 5'd1;
    localparam logic [4:0] PH_ST_D2  = 5'd2;
    localparam logic [4:0] PH_ST_W   = 5'd3;
    localparam logic [4:0] PH_ST_D3  = 5'd4;
    localparam logic [4:0] PH_SP_D1  = 5'd5;
    localparam logic [4:0] PH_SP_D2  = 5'd6;
    localparam logic [4:0] PH_SP_D3  = 5'd7;
    localparam logic [4:0] PH_SP_W   = 5'd8;
    localparam logic [4:0] PH_SP_D4  = 5'd9;
    localparam logic [4:0] PH_WR_D0  = 5'd10;
    localparam logic [4:0] PH_WR_DB  = 5'd11;
    localparam logic [4:0] PH_WR_DB2 = 5'd12;
    localparam logic [4:0] PH_WR_WB  = 5'd13;
    localparam logic [4:0] PH_WR_DA  = 5'd14;
    localparam logic [4:0] PH_WR_DA2 = 5'd15;
    localparam logic [4:0] PH_WR_WA  = 5'd16;
    localparam logic [4:0] PH_WR_DA3 = 5'd17;
    localparam logic [4:0] PH_RD_D0  = 5'd18;
    localparam logic [4:0] PH_RD_D1  = 5'd19;
    localparam logic [4:0] PH_RD_DB  = 5'd20;
    localparam logic [4:0] PH_RD_WB  = 5'd21;
    localparam logic [4:0] PH_RD_DB2 = 5'd22;
    localparam logic [4:0] PH_RD_DA  = 5'd23;
    localparam logic [4:0] PH_RD_DA2 = 5'd24;
    localparam logic [4:0] PH_RD_WA  = 5'd25;
    localparam logic [4:0] PH_RD_DA3 = 5'd26;

    logic [i2cm_pkg::CFG_W-1:0] half_period_reg;
    logic [i2cm_pkg::CFG_W-1:0] stretch_timeout_reg;

    logic [4:0]  phase_reg,         phase_next;
    logic [15:0] delay_count_reg,   delay_count_next;
    logic [15:0] stretch_count_reg, stretch_count_next;
    logic [3:0]  bit_index_reg,     bit_index_next;
    logic [7:0]  shift_reg_reg,     shift_reg_next;
    logic        scl_rel_reg,       scl_rel_next;
    logic        sda_rel_reg,       sda_rel_next;
    logic        nack_flag_reg,     nack_flag_next;
    logic [1:0]  stop_status_reg,   stop_status_next;
    logic [7:0]  rx_hold_reg,       rx_hold_next;

    logic              out_valid_reg, out_valid_next;
    i2cm_pkg::result_t out_reg,       out_next;

    logic [15:0] steps;
    logic [16:0] delay_inc;
    logic        in_wait;
    logic        done;
    logic [1:0]  status;

    assign pop      = !q_stat.empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    assign steps     = (half_period_reg == '0) ? 16'd1 : half_period_reg;
    assign delay_inc = {1'b0, delay_count_reg} + 17'd1;
    assign in_wait   = (phase_reg == PH_ST_W) || (phase_reg == PH_SP_W) ||
                       (phase_reg == PH_WR_WB) || (phase_reg == PH_WR_WA) ||
                       (phase_reg == PH_RD_WB) || (phase_reg == PH_RD_WA);

    always_comb
    begin
        phase_next         = phase_reg;
        delay_count_next   = delay_count_reg;
        stretch_count_next = stretch_count_reg;
        bit_index_next     = bit_index_reg;
        shift_reg_next     = shift_reg_reg;
        scl_rel_next       = scl_rel_reg;
        sda_rel_next       = sda_rel_reg;
        nack_flag_next     = nack_flag_reg;
        stop_status_next   = stop_status_reg;
        rx_hold_next       = rx_hold_reg;
        done               = 1'b0;
        status             = i2cm_pkg::ST_OK;

        if (phase_reg == PH_IDLE)
        begin
            if (head.kind != i2cm_pkg::KIND_NONE)
            begin
                delay_count_next   = '0;
                stretch_count_next = '0;
                bit_index_next     = '0;
            end
            unique case (head.kind)
                i2cm_pkg::KIND_START:
                begin
                    sda_rel_next = 1'b1;
                    phase_next   = PH_ST_D1;
                end
                i2cm_pkg::KIND_STOP:
                begin
                    phase_next = PH_SP_D1;
                end
                i2cm_pkg::KIND_WRITE:
                begin
                    shift_reg_next = head.tx_byte;
                    phase_next     = PH_WR_D0;
                end
                i2cm_pkg::KIND_READ:
                begin
                    shift_reg_next = '0;
                    nack_flag_next = head.send_nack;
                    phase_next     = PH_RD_D0;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else if (in_wait)
        begin
            if (head.scl_in)
            begin
                // slave released SCL: advance the sequence
                stretch_count_next = '0;
                unique case (phase_reg)
                    PH_ST_W:
                    begin
                        sda_rel_next = 1'b0;
                        phase_next   = PH_ST_D3;
                    end
                    PH_SP_W:
                    begin
                        sda_rel_next     = 1'b1;
                        stop_status_next = i2cm_pkg::ST_OK;
                        phase_next       = PH_SP_D4;
                    end
                    PH_WR_WB:
                    begin
                        scl_rel_next   = 1'b0;
                        shift_reg_next = {shift_reg_reg[6:0], 1'b0};
                        bit_index_next = bit_index_reg + 4'd1;
                        if (bit_index_next[3])
                        begin
                            sda_rel_next = 1'b1;
                            phase_next   = PH_WR_DA;
                        end
                        else
                        begin
                            sda_rel_next = shift_reg_reg[6];
                            phase_next   = PH_WR_DB;
                        end
                    end
                    PH_WR_WA:
                    begin
                        nack_flag_next = head.sda_in;
                        phase_next     = PH_WR_DA3;
                    end
                    PH_RD_WB:
                    begin
                        shift_reg_next = {shift_reg_reg[6:0], head.sda_in};
                        scl_rel_next   = 1'b0;
                        bit_index_next = bit_index_reg + 4'd1;
                        phase_next     = PH_RD_DB2;
                    end
                    PH_RD_WA:
                    begin
                        phase_next = PH_RD_DA3;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else if (stretch_count_reg >= stretch_timeout_reg)
            begin
                stretch_count_next = '0;
                if (phase_reg == PH_SP_W)
                begin
                    // stop still finishes its last delay before reporting
                    sda_rel_next     = 1'b1;
                    stop_status_next = i2cm_pkg::ST_TIMEOUT;
                    phase_next       = PH_SP_D4;
                end
                else
                begin
                    if (phase_reg == PH_WR_WB)
                    begin
                        sda_rel_next = 1'b1;
                    end
                    done             = 1'b1;
                    status           = i2cm_pkg::ST_TIMEOUT;
                    phase_next       = PH_IDLE;
                    delay_count_next = '0;
                end
            end
            else
            begin
                stretch_count_next = stretch_count_reg + 16'd1;
            end
        end
        else
        begin
            if (delay_inc >= {1'b0, steps})
            begin
                delay_count_next = '0;
                unique case (phase_reg)
                    PH_ST_D1:
                    begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_ST_D2;
                    end
                    PH_ST_D2:  phase_next = PH_ST_W;
                    PH_ST_D3:
                    begin
                        done       = 1'b1;
                        status     = i2cm_pkg::ST_OK;
                        phase_next = PH_IDLE;
                    end
                    PH_SP_D1:
                    begin
                        sda_rel_next = 1'b0;
                        phase_next   = PH_SP_D2;
                    end
                    PH_SP_D2:
                    begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_SP_D3;
                    end
                    PH_SP_D3:  phase_next = PH_SP_W;
                    PH_SP_D4:
                    begin
                        done       = 1'b1;
                        status     = stop_status_reg;
                        phase_next = PH_IDLE;
                    end
                    PH_WR_D0:
                    begin
                        scl_rel_next = 1'b0;
                        sda_rel_next = shift_reg_reg[7];
                        phase_next   = PH_WR_DB;
                    end
                    PH_WR_DB:
                    begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_WR_DB2;
                    end
                    PH_WR_DB2: phase_next = PH_WR_WB;
                    PH_WR_DA:
                    begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_WR_DA2;
                    end
                    PH_WR_DA2: phase_next = PH_WR_WA;
                    PH_WR_DA3:
                    begin
                        scl_rel_next = 1'b0;
                        done         = 1'b1;
                        status       = {1'b0, nack_flag_reg};
                        phase_next   = PH_IDLE;
                    end
                    PH_RD_D0:
                    begin
                        scl_rel_next = 1'b0;
                        phase_next   = PH_RD_D1;
                    end
                    PH_RD_D1:
                    begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_RD_DB;
                    end
                    PH_RD_DB:  phase_next = PH_RD_WB;
                    PH_RD_DB2:
                    begin
                        if (bit_index_reg[3])
                        begin
                            sda_rel_next = nack_flag_reg;
                            phase_next   = PH_RD_DA;
                        end
                        else
                        begin
                            scl_rel_next = 1'b1;
                            phase_next   = PH_RD_DB;
                        end
                    end
                    PH_RD_DA:
                    begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_RD_DA2;
                    end
                    PH_RD_DA2: phase_next = PH_RD_WA;
                    PH_RD_DA3:
                    begin
                        scl_rel_next = 1'b0;
                        sda_rel_next = 1'b1;
                        rx_hold_next = shift_reg_reg;
                        done         = 1'b1;
                        status       = i2cm_pkg::ST_OK;
                        phase_next   = PH_IDLE;
                    end
                    default:   phase_next = PH_IDLE;
                endcase
                if (done)
                begin
                    stretch_count_next = '0;
                end
            end
            else
            begin
                delay_count_next = delay_inc[15:0];
            end
        end
    end

    always_comb
    begin
        out_next.scl_drive_low = ~scl_rel_next;
        out_next.sda_drive_low = ~sda_rel_next;
        out_next.ready_res     = (phase_next == PH_IDLE);
        out_next.done_res      = done;
        out_next.status        = status;
        out_next.rx_byte       = rx_hold_next;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg     <= i2cm_pkg::HALF_PERIOD_RST;
            stretch_timeout_reg <= i2cm_pkg::STRETCH_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cm_pkg::REG_HALF_PERIOD:     half_period_reg     <= cfg_data;
                i2cm_pkg::REG_STRETCH_TIMEOUT: stretch_timeout_reg <= cfg_data;
                default:                       half_period_reg     <= half_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            delay_count_reg   <= '0;
            stretch_count_reg <= '0;
            bit_index_reg     <= '0;
            shift_reg_reg     <= '0;
            scl_rel_reg       <= 1'b1;
            sda_rel_reg       <= 1'b1;
            nack_flag_reg     <= 1'b0;
            stop_status_reg   <= i2cm_pkg::ST_OK;
            rx_hold_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg         <= phase_next;
                delay_count_reg   <= delay_count_next;
                stretch_count_reg <= stretch_count_next;
                bit_index_reg     <= bit_index_next;
                shift_reg_reg     <= shift_reg_next;
                scl_rel_reg       <= scl_rel_next;
                sda_rel_reg       <= sda_rel_next;
                nack_flag_reg     <= nack_flag_next;
                stop_status_reg   <= stop_status_next;
                rx_hold_reg       <= rx_hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    as_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> out_reg.ready_res)
        else $error("finished command did not return to idle");
    as_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != i2cm_pkg::ST_OK)) |-> out_reg.done_res)
        else $error("status reported without done");
    as_wait_scl_released: assert property (@(posedge clk) disable iff (!rst_n)
        in_wait |-> scl_rel_reg)
        else $error("clock stretch wait entered with SCL held low");
    as_idle_none: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (phase_reg == PH_IDLE) && (head.kind == i2cm_pkg::KIND_NONE))
        |=> (phase_reg == PH_IDLE))
        else $error("engine left idle without a command");

endmodule

// ===== tb/sv/i2cm_bus_checker.sv =====
// Checker for the I2C master bit engine: predicts every tick's result and compares it.
`timescale 1ns / 1ps

module i2cm_bus_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [i2cm_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [i2cm_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_W-1:0]      cfg_data,
    output int unsigned                     fail_count,
    output int unsigned                     pending
);

    typedef enum logic [4:0] {
        IDLE_PH,
        STA_SETUP, STA_RISE, STA_WAIT, STA_HOLD,
        STO_LOW, STO_SDA, STO_RISE, STO_WAIT, STO_END,
        WR_ENTRY, WR_BIT_LOW, WR_BIT_HIGH, WR_BIT_WAIT,
        WR_ACK_LOW, WR_ACK_HIGH, WR_ACK_WAIT, WR_END,
        RD_ENTRY, RD_FIRST, RD_BIT_HIGH, RD_BIT_WAIT, RD_BIT_LOW,
        RD_ACK_LOW, RD_ACK_HIGH, RD_ACK_WAIT, RD_END
    } bus_phase_t;

    bus_phase_t  phase;
    logic [15:0] cfg_half;
    logic [15:0] cfg_tmo;
    logic [15:0] dly_cnt;
    logic [15:0] str_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic        scl_rel;
    logic        sda_rel;
    logic        ack_bit;
    logic [1:0]  stop_st;
    logic [7:0]  rx_last;
    logic        done_now;
    logic [1:0]  status_now;

    i2cm_pkg::result_t expected_results[$];
    int unsigned       result_idx;

    function automatic void finish_cmd(input logic [1:0] st);
        done_now   = 1'b1;
        status_now = st;
        phase      = IDLE_PH;
        dly_cnt    = '0;
        str_cnt    = '0;
    endfunction

    function automatic logic is_wait(input bus_phase_t p);
        case (p)
            STA_WAIT, STO_WAIT, WR_BIT_WAIT, WR_ACK_WAIT, RD_BIT_WAIT, RD_ACK_WAIT:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void delay_elapsed();
        case (phase)
            STA_SETUP:   begin scl_rel = 1'b1; phase = STA_RISE; end
            STA_RISE:    phase = STA_WAIT;
            STA_HOLD:    finish_cmd(i2cm_pkg::ST_OK);
            STO_LOW:     begin sda_rel = 1'b0; phase = STO_SDA; end
            STO_SDA:     begin scl_rel = 1'b1; phase = STO_RISE; end
            STO_RISE:    phase = STO_WAIT;
            STO_END:     finish_cmd(stop_st);
            WR_ENTRY:
            begin
                scl_rel = 1'b0;
                sda_rel = shreg[7];
                phase   = WR_BIT_LOW;
            end
            WR_BIT_LOW:  begin scl_rel = 1'b1; phase = WR_BIT_HIGH; end
            WR_BIT_HIGH: phase = WR_BIT_WAIT;
            WR_ACK_LOW:  begin scl_rel = 1'b1; phase = WR_ACK_HIGH; end
            WR_ACK_HIGH: phase = WR_ACK_WAIT;
            WR_END:
            begin
                scl_rel = 1'b0;
                finish_cmd({1'b0, ack_bit});
            end
            RD_ENTRY:    begin scl_rel = 1'b0; phase = RD_FIRST; end
            RD_FIRST:    begin scl_rel = 1'b1; phase = RD_BIT_HIGH; end
            RD_BIT_HIGH: phase = RD_BIT_WAIT;
            RD_BIT_LOW:
            begin
                if (bit_cnt >= 4'd8)
                begin
                    sda_rel = ack_bit;
                    phase   = RD_ACK_LOW;
                end
                else
                begin
                    scl_rel = 1'b1;
                    phase   = RD_BIT_HIGH;
                end
            end
            RD_ACK_LOW:  begin scl_rel = 1'b1; phase = RD_ACK_HIGH; end
            RD_ACK_HIGH: phase = RD_ACK_WAIT;
            RD_END:
            begin
                scl_rel = 1'b0;
                sda_rel = 1'b1;
                rx_last = shreg;
                finish_cmd(i2cm_pkg::ST_OK);
            end
            default:     phase = IDLE_PH;
        endcase
    endfunction

    function automatic void scl_seen_high(input logic sda);
        case (phase)
            STA_WAIT:    begin sda_rel = 1'b0; phase = STA_HOLD; end
            STO_WAIT:
            begin
                sda_rel = 1'b1;
                stop_st = i2cm_pkg::ST_OK;
                phase   = STO_END;
            end
            WR_BIT_WAIT:
            begin
                scl_rel = 1'b0;
                shreg   = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8)
                begin
                    sda_rel = 1'b1;
                    phase   = WR_ACK_LOW;
                end
                else
                begin
                    sda_rel = shreg[7];
                    phase   = WR_BIT_LOW;
                end
            end
            WR_ACK_WAIT: begin ack_bit = sda; phase = WR_END; end
            RD_BIT_WAIT:
            begin
                shreg   = {shreg[6:0], sda};
                scl_rel = 1'b0;
                bit_cnt = bit_cnt + 4'd1;
                phase   = RD_BIT_LOW;
            end
            RD_ACK_WAIT: phase = RD_END;
            default:     phase = IDLE_PH;
        endcase
    endfunction

    function automatic void stretch_expired();
        // A stop still frees SDA and runs out its last delay before reporting.
        if (phase == STO_WAIT)
        begin
            sda_rel = 1'b1;
            stop_st = i2cm_pkg::ST_TIMEOUT;
            phase   = STO_END;
        end
        else
        begin
            if (phase == WR_BIT_WAIT)
                sda_rel = 1'b1;
            finish_cmd(i2cm_pkg::ST_TIMEOUT);
        end
    endfunction

    function automatic i2cm_pkg::result_t advance_engine(input i2cm_pkg::tick_t t);
        logic [15:0]       steps;
        i2cm_pkg::result_t r;
        steps      = (cfg_half == '0) ? 16'd1 : cfg_half;
        done_now   = 1'b0;
        status_now = i2cm_pkg::ST_OK;
        if (phase == IDLE_PH)
        begin
            if (t.kind inside {i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP,
                               i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ})
            begin
                dly_cnt = '0;
                str_cnt = '0;
                bit_cnt = '0;
                case (t.kind)
                    i2cm_pkg::CMD_START: begin sda_rel = 1'b1; phase = STA_SETUP; end
                    i2cm_pkg::CMD_STOP:  phase = STO_LOW;
                    i2cm_pkg::CMD_WRITE: begin shreg = t.tx_byte; phase = WR_ENTRY; end
                    default:
                    begin
                        shreg   = '0;
                        ack_bit = t.send_nack;
                        phase   = RD_ENTRY;
                    end
                endcase
            end
        end
        else if (is_wait(phase))
        begin
            if (t.scl_in)
            begin
                str_cnt = '0;
                scl_seen_high(t.sda_in);
            end
            else if (str_cnt >= cfg_tmo)
            begin
                str_cnt = '0;
                stretch_expired();
            end
            else
                str_cnt = str_cnt + 16'd1;
        end
        else
        begin
            dly_cnt = dly_cnt + 16'd1;
            if (dly_cnt >= steps)
            begin
                dly_cnt = '0;
                delay_elapsed();
            end
        end
        r.scl_drive_low = ~scl_rel;
        r.sda_drive_low = ~sda_rel;
        r.ready_res     = (phase == IDLE_PH);
        r.done_res      = done_now;
        r.status        = status_now;
        r.rx_byte       = rx_last;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("result %0d: %s expected %0h got %0h", result_idx, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        i2cm_pkg::tick_t   t;
        i2cm_pkg::result_t want;
        i2cm_pkg::result_t got;
        if (!rst_n)
        begin
            phase      = IDLE_PH;
            cfg_half   = i2cm_pkg::HALF_PERIOD_RST;
            cfg_tmo    = i2cm_pkg::STRETCH_TIMEOUT_RST;
            dly_cnt    = '0;
            str_cnt    = '0;
            bit_cnt    = '0;
            shreg      = '0;
            scl_rel    = 1'b1;
            sda_rel    = 1'b1;
            ack_bit    = 1'b0;
            stop_st    = i2cm_pkg::ST_OK;
            rx_last    = '0;
            done_now   = 1'b0;
            status_now = i2cm_pkg::ST_OK;
            expected_results.delete();
            result_idx = 0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == i2cm_pkg::REG_HALF_PERIOD)
                    cfg_half = cfg_data;
                else if (cfg_index == i2cm_pkg::REG_STRETCH_TIMEOUT)
                    cfg_tmo = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                t.kind      = s_tuser;
                t.tx_byte   = s_tdata[7:0];
                t.send_nack = s_tdata[8];
                t.scl_in    = s_tdata[9];
                t.sda_in    = s_tdata[10];
                expected_results.push_back(advance_engine(t));
            end
            if (m_tvalid && m_tready)
            begin
                got = i2cm_pkg::result_t'(m_tdata[$bits(i2cm_pkg::result_t)-1:0]);
                if (expected_results.size() == 0)
                    flag_mismatch("result with nothing pending", 0, int'(got));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.scl_drive_low !== want.scl_drive_low)
                        flag_mismatch("scl_drive_low", int'(want.scl_drive_low),
                                      int'(got.scl_drive_low));
                    if (got.sda_drive_low !== want.sda_drive_low)
                        flag_mismatch("sda_drive_low", int'(want.sda_drive_low),
                                      int'(got.sda_drive_low));
                    if (got.ready_res !== want.ready_res)
                        flag_mismatch("ready_res", int'(want.ready_res), int'(got.ready_res));
                    if (got.done_res !== want.done_res)
                        flag_mismatch("done_res", int'(want.done_res), int'(got.done_res));
                    if (got.status !== want.status)
                        flag_mismatch("status", int'(want.status), int'(got.status));
                    if (got.rx_byte !== want.rx_byte)
                        flag_mismatch("rx_byte", int'(want.rx_byte), int'(got.rx_byte));
                end
                result_idx++;
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/sv/i2c_master_bit_engine_tb.sv =====
// Testbench top for the I2C master bit engine: clock, reset, bus tick stimulus and verdict.
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;

    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int WAIT_LIMIT  = 2000;
    localparam int HOLD_OFF    = 60;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [i2cm_pkg::IN_DATA_W-1:0]  s_tdata;   // tx_byte[7:0], send_nack, scl_in, sda_in
    logic [i2cm_pkg::IN_USER_W-1:0]  s_tuser;   // command[2:0]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [i2cm_pkg::OUT_DATA_W-1:0] m_tdata;   // scl_drive_low, sda_drive_low, ready_res,
                                                // done_res, status[1:0], rx_byte[7:0]
    logic                            cfg_we;
    logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [i2cm_pkg::CFG_W-1:0]      cfg_data;

    int unsigned fail_count;
    int unsigned pending;

    i2cm_pkg::result_t out_word;
    logic        s_taken;
    logic        m_taken;
    int          ticks_sent;
    int          results_seen;
    int          last_idle_idx;
    logic [1:0]  last_status;
    int          stall_cycles;
    int          gap_max;
    int          scl_low_pct;
    int          noise_pct;
    int          hold_req;
    int          commands_issued;
    int          frames;
    int          cfg_writes;

    i2c_master_bit_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2cm_bus_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    assign out_word = i2cm_pkg::result_t'(m_tdata[$bits(i2cm_pkg::result_t)-1:0]);

    // Track accepted transactions and the latest tick that left the engine idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_taken       <= 1'b0;
            m_taken       <= 1'b0;
            results_seen  <= 0;
            last_idle_idx <= -1;
            last_status   <= i2cm_pkg::ST_OK;
        end
        else
        begin
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (out_word.ready_res)
                    last_idle_idx <= results_seen;
                if (out_word.done_res)
                    last_status <= out_word.status;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic bus_scl();
        return ($urandom_range(99, 0) >= scl_low_pct);
    endfunction

    task automatic push_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic nk,
                             input logic scl, input logic sda);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = cmd;
        s_tdata  = {5'b0, sda, scl, nk, tx};
        s_tvalid = 1'b1;
        do @(negedge clk); while (!s_taken);
        ticks_sent++;
    endtask

    // Keep the bus ticking until a result at or after tick idx shows the engine idle.
    task automatic wait_idle(input int idx);
        int n;
        n = 0;
        while (last_idle_idx < idx)
        begin
            if (n >= WAIT_LIMIT)
            begin
                $display("engine not idle after %0d ticks", WAIT_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
            n++;
            if ($urandom_range(99, 0) < noise_pct)
                push_tick(3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom_range(1, 0)),
                          bus_scl(), 1'($urandom_range(1, 0)));
            else
                push_tick(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(1, 0)),
                          bus_scl(), 1'($urandom_range(1, 0)));
        end
    endtask

    task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic nk);
        int idx;
        idx = ticks_sent;
        push_tick(cmd, tx, nk, bus_scl(), 1'($urandom_range(1, 0)));
        commands_issued++;
        wait_idle(idx);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        do @(negedge clk); while (results_seen != ticks_sent);
    endtask

    // Drain, and tick the engine on until the last result leaves it idle.
    task automatic settle();
        noise_pct = 0;
        drain();
        while (last_idle_idx != results_seen - 1)
        begin
            push_tick(i2cm_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1);
            drain();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic program_timing(input logic [15:0] half, input logic [15:0] tmo);
        cfg_we    = 1'b1;
        cfg_index = i2cm_pkg::REG_HALF_PERIOD;
        cfg_data  = half;
        @(negedge clk);
        cfg_index = i2cm_pkg::REG_STRETCH_TIMEOUT;
        cfg_data  = tmo;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_writes += 2;
    endtask

    task automatic run_phase(input logic [15:0] half, input logic [15:0] tmo, input int low_pct,
                             input int gmax, input int noise, input int n_ticks,
                             input bit hold);
        int         first;
        bit         paused;
        bit         is_read;
        logic [7:0] addr;
        int         nbytes;
        settle();
        program_timing(half, tmo);
        scl_low_pct = low_pct;
        gap_max     = gmax;
        noise_pct   = noise;
        if (hold)
            hold_req = HOLD_OFF;
        first  = ticks_sent;
        paused = 1'b0;
        while (ticks_sent - first < n_ticks)
        begin
            frames++;
            // Pause the sender once per phase until every result is back.
            if (!paused && ticks_sent - first >= n_ticks / 2)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(9, 0) == 0)
            begin
                // Broken frame: raw commands in any order, unused codes included.
                repeat ($urandom_range(4, 1))
                    run_command(3'($urandom_range(7, 0)), 8'($urandom),
                                1'($urandom_range(1, 0)));
            end
            else
            begin
                is_read = 1'($urandom_range(1, 0));
                addr    = 8'($urandom);
                addr[0] = is_read;
                run_command(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom_range(1, 0)));
                run_command(i2cm_pkg::CMD_WRITE, addr, 1'($urandom_range(1, 0)));
                nbytes = $urandom_range(4, 1);
                for (int k = 0; k < nbytes && last_status == i2cm_pkg::ST_OK; k++)
                begin
                    if (is_read)
                        run_command(i2cm_pkg::CMD_READ, 8'($urandom), k == nbytes - 1);
                    else
                        run_command(i2cm_pkg::CMD_WRITE, 8'($urandom),
                                    1'($urandom_range(1, 0)));
                end
                if (last_status == i2cm_pkg::ST_OK && $urandom_range(4, 0) == 0)
                begin
                    run_command(i2cm_pkg::CMD_START, 8'($urandom), 1'b0);
                    run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0);
                end
                run_command(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom_range(1, 0)));
            end
        end
    endtask

    // Result side: random hold per transaction, plus a long hold-off on request.
    initial
    begin
        int w;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                w        = hold_req;
                hold_req = 0;
            end
            else
                w = $urandom_range(gap_max, 0);
            if (w > 0)
            begin
                m_tready = 1'b0;
                repeat (w) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(negedge clk); while (!m_taken);
        end
    end

    initial
    begin
        int idx;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = i2cm_pkg::CMD_NONE;
        cfg_we          = 1'b0;
        cfg_index       = i2cm_pkg::REG_HALF_PERIOD;
        cfg_data        = '0;
        ticks_sent      = 0;
        gap_max         = 8;
        scl_low_pct     = 0;
        noise_pct       = 0;
        hold_req        = 0;
        commands_issued = 0;
        frames          = 0;
        cfg_writes      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every command at reset timing, byte extremes, ignored codes.
        run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1);
        run_command(i2cm_pkg::CMD_READ, 8'hFF, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
        // Second command lands while the engine is busy and is dropped.
        idx = ticks_sent;
        push_tick(i2cm_pkg::CMD_START, 8'hA5, 1'b0, 1'b1, 1'b1);
        push_tick(i2cm_pkg::CMD_READ, 8'h5A, 1'b1, 1'b1, 1'b0);
        commands_issued += 2;
        wait_idle(idx);
        run_command(CMD_UNUSED_LO, 8'h3C, 1'b0);
        run_command(CMD_UNUSED_MID, 8'hC3, 1'b1);
        run_command(CMD_UNUSED_HI, 8'h7E, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);

        // Zero stretch timeout with SCL held low: every release times out at once.
        settle();
        program_timing(16'd1, 16'd0);
        scl_low_pct = 100;
        run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 8'h81, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
        scl_low_pct = 0;

        run_phase(16'd1, 16'd2, 30, 8, 5, 60, 1'b1);
        run_phase(16'd0, 16'd0, 10, 0, 5, 60, 1'b0);
        run_phase(16'd3, 16'd65535, 5, 8, 5, 40, 1'b0);

        settle();
        repeat (8) @(negedge clk);
        $display("covered %0d ticks, %0d commands in %0d frames, %0d register writes",
                 ticks_sent, commands_issued, frames, cfg_writes);
        $display("half period 0, 1, 3 and 5, stretch timeout 0 to 65535, ACK/NACK and timeouts");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
